### rtl/wsc_pkg.sv
// Package: widths, codes, constants and helpers for the waypoint steering controller.
package wsc_pkg;

   localparam int ROUTE_DEPTH_DEF = 16;
   localparam int BODY_COUNT_DEF  = 8;

   localparam logic [31:0] ARRIVE_RST = 32'd160000;
   localparam logic [15:0] TURN_RST   = 16'hA45D;   // -23459
   localparam logic [15:0] DRIVE_RST  = 16'h81F2;   // -32270
   localparam logic [7:0]  REPEAT_RST = 8'd20;
   localparam logic [3:0]  SKIP_RST   = 4'd4;

   typedef enum logic [2:0] {
      CSR_ARRIVE = 3'd0,
      CSR_TURN   = 3'd1,
      CSR_DRIVE  = 3'd2,
      CSR_REPEAT = 3'd3,
      CSR_SKIP   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_STOP  = 2'd0,
      CMD_TURN  = 2'd1,
      CMD_DRIVE = 2'd2,
      CMD_NONE  = 2'd3
   } drive_cmd_type;

   localparam logic [2:0] DEST_KITCHEN     = 3'd2;
   localparam logic [2:0] DEST_TABLE_ONE   = 3'd3;
   localparam logic [2:0] DEST_TABLE_TWO   = 3'd4;
   localparam logic [2:0] DEST_TABLE_THREE = 3'd5;

   // preset route at reset
   function automatic logic [2:0] preset_route(input int idx);
      case (idx)
         0:       preset_route = DEST_KITCHEN;
         1:       preset_route = DEST_TABLE_ONE;
         2:       preset_route = DEST_TABLE_TWO;
         3:       preset_route = DEST_KITCHEN;
         4:       preset_route = DEST_TABLE_THREE;
         default: preset_route = 3'd0;
      endcase
   endfunction

   // controller to datapath
   typedef struct packed {
      logic store_body;   // write sample position
      logic order;        // apply order word
      logic load_a;       // stage 1: vectors
      logic load_b;       // stage 2: squares and products
      logic load_c;       // stage 3: sums
      logic load_d;       // stage 4: dot square, magnitude product, limit squares
      logic load_e;       // stage 5: limit square times magnitude product, in halves
      logic load_f;       // stage 6: join halves, compare both tests
      logic decide;       // update decision state, build result
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic eval_frame;   // sample word closes an evaluated frame
      logic has_rsp;      // decision produced a result word
   } dp_stat_type;

endpackage

### rtl/wsc_ctrl.sv
// Sequencer: accepts a word, steps the datapath through its stages, holds the result.
module wsc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_command,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output wsc_pkg::dp_cmd_type  cmd,
   input  wsc_pkg::dp_stat_type stat
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b0_0000_0001,
      ST_A    = 9'b0_0000_0010,
      ST_B    = 9'b0_0000_0100,
      ST_C    = 9'b0_0000_1000,
      ST_D    = 9'b0_0001_0000,
      ST_E    = 9'b0_0010_0000,
      ST_F    = 9'b0_0100_0000,
      ST_DEC  = 9'b0_1000_0000,
      ST_OUT  = 9'b1_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      cmd            = '0;
      state_in       = state_ff;
      cmd.store_body = accept && !req_command;
      cmd.order      = accept && req_command;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !req_command && stat.eval_frame) state_in = ST_A;
         end
         ST_A: begin
            cmd.load_a = 1'b1;
            state_in   = ST_B;
         end
         ST_B: begin
            cmd.load_b = 1'b1;
            state_in   = ST_C;
         end
         ST_C: begin
            cmd.load_c = 1'b1;
            state_in   = ST_D;
         end
         ST_D: begin
            cmd.load_d = 1'b1;
            state_in   = ST_E;
         end
         ST_E: begin
            cmd.load_e = 1'b1;
            state_in   = ST_F;
         end
         ST_F: begin
            cmd.load_f = 1'b1;
            state_in   = ST_DEC;
         end
         ST_DEC: begin
            cmd.decide = 1'b1;
            state_in   = stat.has_rsp ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

### rtl/wsc_dp.sv
// Datapath: body and route stores, vector arithmetic, cosine tests and decision state.
module wsc_dp #(
   parameter int ROUTE_DEPTH = wsc_pkg::ROUTE_DEPTH_DEF,
   parameter int BODY_COUNT  = wsc_pkg::BODY_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wsc_pkg::dp_cmd_type  cmd,
   output wsc_pkg::dp_stat_type stat,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data,
   input  logic [2:0]           req_body_index,
   input  logic signed [15:0]   req_pos_x,
   input  logic signed [15:0]   req_pos_z,
   input  logic                 req_frame_end,
   input  logic [2:0]           req_order_dest,
   output logic [1:0]           rsp_drive_cmd,
   output logic [2:0]           rsp_target,
   output logic                 rsp_arrived,
   output logic                 rsp_resent
);

   localparam int RW = $clog2(ROUTE_DEPTH);
   localparam int CW = $clog2(ROUTE_DEPTH + 1);
   localparam int BW = $clog2(BODY_COUNT);

   // configuration
   logic [31:0]        arrive_ff;
   logic signed [15:0] turn_ff, drive_ff;
   logic [7:0]         replim_ff;
   logic [3:0]         skip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arrive_ff <= wsc_pkg::ARRIVE_RST;
         turn_ff   <= wsc_pkg::TURN_RST;
         drive_ff  <= wsc_pkg::DRIVE_RST;
         replim_ff <= wsc_pkg::REPEAT_RST;
         skip_ff   <= wsc_pkg::SKIP_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            wsc_pkg::CSR_ARRIVE: arrive_ff <= csr_data;
            wsc_pkg::CSR_TURN:   turn_ff   <= csr_data[15:0];
            wsc_pkg::CSR_DRIVE:  drive_ff  <= csr_data[15:0];
            wsc_pkg::CSR_REPEAT: replim_ff <= csr_data[7:0];
            wsc_pkg::CSR_SKIP:   skip_ff   <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // body store, registers per body
   logic signed [15:0] bx_ff [BODY_COUNT];
   logic signed [15:0] bz_ff [BODY_COUNT];
   logic               body_ok;

   assign body_ok = ({29'd0, req_body_index} < BODY_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BODY_COUNT; i++) begin
            bx_ff[i] <= '0;
            bz_ff[i] <= '0;
         end
      end else if (cmd.store_body && body_ok) begin
         bx_ff[BW'(req_body_index)] <= req_pos_x;
         bz_ff[BW'(req_body_index)] <= req_pos_z;
      end
   end

   // route store and frame phase
   logic [2:0]    route_ff [ROUTE_DEPTH];
   logic [CW-1:0] rcount_ff, rstep_ff;
   logic [3:0]    phase_ff;
   logic [2:0]    last_entry;
   logic          dup;
   logic          frame_due;

   assign last_entry = (rcount_ff != '0) ? route_ff[RW'(rcount_ff - 1'b1)] : 3'd0;
   assign dup        = (rcount_ff != '0) && (last_entry == req_order_dest);
   assign frame_due  = req_frame_end && (phase_ff == skip_ff);

   logic adv;   // route advance, from decision

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROUTE_DEPTH; i++) route_ff[i] <= wsc_pkg::preset_route(i);
         rcount_ff <= CW'(5);
         phase_ff  <= 4'd1;
      end else begin
         if (cmd.order && !dup && rcount_ff < CW'(ROUTE_DEPTH)) begin
            route_ff[rcount_ff[RW-1:0]] <= req_order_dest;
            rcount_ff <= rcount_ff + 1'b1;
         end
         if (cmd.store_body && req_frame_end) begin
            if (phase_ff == skip_ff) phase_ff <= 4'd0;
            else                     phase_ff <= phase_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset)   rstep_ff <= '0;
      else if (adv) rstep_ff <= rstep_ff + 1'b1;
   end

   // stage 1: target and vectors
   logic [2:0]         tgt_ff;
   logic               tvalid_ff;
   logic signed [16:0] hx_ff, hz_ff, tx_ff, tz_ff;
   logic [2:0]         tgt_in;
   logic signed [15:0] tbx, tbz;

   assign tgt_in = route_ff[rstep_ff[RW-1:0]];
   assign tbx = ({29'd0, tgt_in} < BODY_COUNT) ? bx_ff[BW'(tgt_in)] : 16'sd0;
   assign tbz = ({29'd0, tgt_in} < BODY_COUNT) ? bz_ff[BW'(tgt_in)] : 16'sd0;

   always_ff @(posedge clock) begin
      if (cmd.load_a) begin
         tgt_ff    <= tgt_in;
         tvalid_ff <= (rstep_ff < rcount_ff) && (tgt_in != 3'd0);
         hx_ff     <= 17'(bx_ff[1]) - 17'(bx_ff[0]);
         hz_ff     <= 17'(bz_ff[1]) - 17'(bz_ff[0]);
         tx_ff     <= 17'(tbx) - 17'(bx_ff[0]);
         tz_ff     <= 17'(tbz) - 17'(bz_ff[0]);
      end
   end

   // stage 2: products
   logic signed [33:0] hxx_ff, hzz_ff, txx_ff, tzz_ff, dx_ff, dz_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_b) begin
         hxx_ff <= hx_ff * hx_ff;
         hzz_ff <= hz_ff * hz_ff;
         txx_ff <= tx_ff * tx_ff;
         tzz_ff <= tz_ff * tz_ff;
         dx_ff  <= hx_ff * tx_ff;
         dz_ff  <= hz_ff * tz_ff;
      end
   end

   // stage 3: magnitudes and dot product
   logic [33:0]        hm_ff, tm_ff;
   logic signed [34:0] dot_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_c) begin
         hm_ff  <= 34'(hxx_ff) + 34'(hzz_ff);
         tm_ff  <= 34'(txx_ff) + 34'(tzz_ff);
         dot_ff <= 35'(dx_ff) + 35'(dz_ff);
      end
   end

   // stages 4 to 6: dot^2 * 2^30 against lim^2 * hm * tm; the 32x68 product
   // is taken as two 32x34 halves and joined in the compare stage
   logic [33:0] adot;
   logic [67:0] dotsq_ff, mm_ff;
   logic [15:0] aturn, adrive;
   logic [31:0] lt2_ff, ld2_ff;
   logic [65:0] pt_lo_ff, pt_hi_ff, pd_lo_ff, pd_hi_ff;
   logic [97:0] lhs;
   logic [99:0] rhs_t, rhs_d;
   logic        gt_t_ff, lt_t_ff, gt_d_ff, lt_d_ff;

   assign adot   = dot_ff[34] ? 34'(-dot_ff) : dot_ff[33:0];
   assign aturn  = turn_ff[15] ? 16'(-turn_ff) : turn_ff;
   assign adrive = drive_ff[15] ? 16'(-drive_ff) : drive_ff;
   assign lhs    = {dotsq_ff, 30'd0};
   assign rhs_t  = {pt_hi_ff, 34'd0} + {34'd0, pt_lo_ff};
   assign rhs_d  = {pd_hi_ff, 34'd0} + {34'd0, pd_lo_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_d) begin
         dotsq_ff <= adot * adot;
         mm_ff    <= hm_ff * tm_ff;
         lt2_ff   <= aturn * aturn;
         ld2_ff   <= adrive * adrive;
      end
      if (cmd.load_e) begin
         pt_lo_ff <= lt2_ff * mm_ff[33:0];
         pt_hi_ff <= lt2_ff * mm_ff[67:34];
         pd_lo_ff <= ld2_ff * mm_ff[33:0];
         pd_hi_ff <= ld2_ff * mm_ff[67:34];
      end
      if (cmd.load_f) begin
         gt_t_ff <= {2'b0, lhs} > rhs_t;
         lt_t_ff <= {2'b0, lhs} < rhs_t;
         gt_d_ff <= {2'b0, lhs} > rhs_d;
         lt_d_ff <= {2'b0, lhs} < rhs_d;
      end
   end

   // cosine tests
   logic dpos, dneg, turn_hit, drive_hit;
   assign dpos = !dot_ff[34] && (dot_ff != '0);
   assign dneg = dot_ff[34];
   always_comb begin
      if (!turn_ff[15]) turn_hit = dpos && gt_t_ff;
      else              turn_hit = !dneg || lt_t_ff;
      // drive: cos < drive limit; a zero limit needs a strictly negative dot
      if (!drive_ff[15] && drive_ff != '0) drive_hit = !dpos || lt_d_ff;
      else                                 drive_hit = dneg && gt_d_ff;
   end

   // decision state
   logic [1:0] dstate_ff;
   logic [3:0] last_ff;
   logic [7:0] rep_ff;
   logic [7:0] rep_sat;
   logic       rep_fire;

   logic       emit, emit_arr, emit_rs, set_last, clr_rep, inc_rep;
   logic [1:0] ecmd;

   assign rep_sat  = (rep_ff == 8'd255) ? rep_ff : rep_ff + 8'd1;
   assign rep_fire = rep_sat > replim_ff;

   always_comb begin
      emit = 1'b0; emit_arr = 1'b0; emit_rs = 1'b0;
      set_last = 1'b0; clr_rep = 1'b0; inc_rep = 1'b0;
      ecmd = wsc_pkg::CMD_STOP;
      if (tvalid_ff) begin
         if ({30'd0, tm_ff} < {32'd0, arrive_ff}) begin
            ecmd = wsc_pkg::CMD_STOP;
            if (dstate_ff != wsc_pkg::CMD_STOP || last_ff != {1'b0, tgt_ff}) begin
               emit = 1'b1; emit_arr = 1'b1; set_last = 1'b1; clr_rep = 1'b1;
            end else begin
               inc_rep = 1'b1;
               emit = rep_fire; emit_rs = rep_fire;
            end
         end else if (hm_ff != '0 && tm_ff != '0) begin
            if (turn_hit) begin
               ecmd = wsc_pkg::CMD_TURN;
               if (dstate_ff != wsc_pkg::CMD_TURN) begin
                  emit = 1'b1; clr_rep = 1'b1;
               end else begin
                  inc_rep = 1'b1; emit = rep_fire; emit_rs = rep_fire;
               end
            end else if (drive_hit) begin
               if (dstate_ff == wsc_pkg::CMD_TURN) begin
                  ecmd = wsc_pkg::CMD_STOP; emit = 1'b1; clr_rep = 1'b1;
               end else if (dstate_ff != wsc_pkg::CMD_DRIVE) begin
                  ecmd = wsc_pkg::CMD_DRIVE; emit = 1'b1; clr_rep = 1'b1;
               end else begin
                  ecmd = wsc_pkg::CMD_DRIVE;
                  inc_rep = 1'b1; emit = rep_fire; emit_rs = rep_fire;
               end
            end
         end
      end
   end

   assign adv  = cmd.decide && set_last;
   assign stat = '{eval_frame: frame_due, has_rsp: emit};

   always_ff @(posedge clock) begin
      if (reset) begin
         dstate_ff <= wsc_pkg::CMD_NONE;
         last_ff   <= 4'hF;
         rep_ff    <= '0;
      end else if (cmd.decide) begin
         if (emit) dstate_ff <= ecmd;
         if (set_last) last_ff <= {1'b0, tgt_ff};
         if (clr_rep || emit_rs) rep_ff <= '0;
         else if (inc_rep)       rep_ff <= rep_sat;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         rsp_drive_cmd <= ecmd;
         rsp_target    <= tgt_ff;
         rsp_arrived   <= emit_arr;
         rsp_resent    <= emit_rs;
      end
   end

endmodule

### rtl/waypoint_steering_controller_top.sv
// Top level of the waypoint steering controller.
// Input channel req_*: one word per body sample (command 0) or order (command 1).
// Orders append a destination to the route unless it repeats the last entry
// or the route is full. A sample word with frame_end closes a frame; every
// (frame_skip+1)-th frame is evaluated and may give one result word on rsp_*.
// A word that causes no evaluation leaves the block idle. An evaluated
// frame runs seven datapath steps (vectors, products, sums, dot square and
// magnitude product, limit product halves, compare, decide) and then
// presents its result, if any; the next word is taken once that result
// has been delivered, or once the decide step is done when there is none.
// Throughput: one plain word per cycle while idle; no word is taken while a
// frame is evaluated. The wide limit products, split into 32x34 halves,
// set the step count.
// Reset (synchronous, active high) loads default registers, preset route
// and clears the body positions. A stalled result holds rsp_* steady and
// keeps req_stall high until it is taken. csr_* writes only while idle.
module waypoint_steering_controller_top #(
   parameter int ROUTE_DEPTH = wsc_pkg::ROUTE_DEPTH_DEF,
   parameter int BODY_COUNT  = wsc_pkg::BODY_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [2:0]         req_body_index,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_z,
   input  logic               req_frame_end,
   input  logic [2:0]         req_order_dest,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_drive_cmd,
   output logic [2:0]         rsp_target,
   output logic               rsp_arrived,
   output logic               rsp_resent,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   wsc_pkg::dp_cmd_type  cmd;
   wsc_pkg::dp_stat_type stat;

   wsc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .stat        (stat)
   );

   wsc_dp #(
      .ROUTE_DEPTH (ROUTE_DEPTH),
      .BODY_COUNT  (BODY_COUNT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_body_index (req_body_index),
      .req_pos_x      (req_pos_x),
      .req_pos_z      (req_pos_z),
      .req_frame_end  (req_frame_end),
      .req_order_dest (req_order_dest),
      .rsp_drive_cmd  (rsp_drive_cmd),
      .rsp_target     (rsp_target),
      .rsp_arrived    (rsp_arrived),
      .rsp_resent     (rsp_resent)
   );

endmodule

### sim/waypoint_steering_controller_top_tb.sv
// Testbench for the waypoint steering controller: random frames and orders checked against a predictor.
`timescale 1ns / 100ps

module waypoint_steering_controller_top_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [1:0] cmd;
      logic [2:0] tgt;
      logic       arr;
      logic       rs;
   } steer_word_type;

   typedef enum {FR_RANDOM, FR_NEAR, FR_OPPOSE, FR_ALIGN, FR_ZERO, FR_SAME, FR_EXTREME}
      frame_kind_type;

   // predicted controller state and the queue of steering words still to arrive
   class steer_book_type;
      logic [31:0]            arrive_sq;
      logic signed [15:0]     turn_lim, drive_lim;
      logic [7:0]             rep_lim;
      logic [3:0]             skip;
      logic signed [15:0]     bx[8], bz[8];
      logic [2:0]             route[16];
      int                     route_count, route_step, last_tgt, rep_cnt;
      wsc_pkg::drive_cmd_type dstate;
      logic [3:0]             phase;
      steer_word_type         expected_words[$];
      int                     errors;

      function new();
         arrive_sq = wsc_pkg::ARRIVE_RST; turn_lim = wsc_pkg::TURN_RST;
         drive_lim = wsc_pkg::DRIVE_RST;
         rep_lim = wsc_pkg::REPEAT_RST; skip = wsc_pkg::SKIP_RST;
         foreach (bx[i]) begin bx[i] = '0; bz[i] = '0; end
         foreach (route[i]) route[i] = wsc_pkg::preset_route(i);
         route_count = 5; route_step = 0; last_tgt = 15; rep_cnt = 0;
         dstate = wsc_pkg::CMD_NONE; phase = 4'd1; errors = 0;
      endfunction

      function void set_reg(wsc_pkg::csr_index_type idx, logic [31:0] v);
         case (idx)
            wsc_pkg::CSR_ARRIVE: arrive_sq = v;
            wsc_pkg::CSR_TURN:   turn_lim  = v[15:0];
            wsc_pkg::CSR_DRIVE:  drive_lim = v[15:0];
            wsc_pkg::CSR_REPEAT: rep_lim   = v[7:0];
            wsc_pkg::CSR_SKIP:   skip      = v[3:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function logic [2:0] cur_target();
         return (route_step < route_count) ? route[route_step] : 3'd0;
      endfunction

      function logic [2:0] tail_dest();
         return route[route_count-1];
      endfunction

      function bit cos_above(longint dot, longint unsigned m1, longint unsigned m2,
                             longint lim);
         longint unsigned a, l, t;
         logic [127:0] lhs, rhs;
         a = (dot < 0) ? -dot : dot;
         a = a << 15;
         l = (lim < 0) ? -lim : lim;
         lhs = {64'd0, a} * {64'd0, a};
         t = l * l * m1;   // 64-bit product; it stays below 2^64 and does not wrap
         rhs = {64'd0, t} * {64'd0, m2};
         if (lim >= 0) return (dot > 0) && (lhs > rhs);
         if (dot >= 0) return 1'b1;
         return lhs < rhs;
      endfunction

      function void push(wsc_pkg::drive_cmd_type c, logic [2:0] tg, logic a, logic r);
         steer_word_type w;
         w.cmd = c; w.tgt = tg; w.arr = a; w.rs = r;
         dstate = c;
         expected_words.push_back(w);
      endfunction

      function void repeat_or_resend(wsc_pkg::drive_cmd_type c, logic [2:0] tg);
         if (rep_cnt < 255) rep_cnt++;
         if (rep_cnt > rep_lim) begin
            rep_cnt = 0;
            push(c, tg, 1'b0, 1'b1);
         end
      endfunction

      function void evaluate();
         logic [2:0] tg;
         longint hx, hz, tx, tz, dot;
         longint unsigned hm, tm;
         if (route_step >= route_count) return;
         tg = route[route_step];
         if (tg == 0) return;
         hx = longint'(bx[1]) - bx[0]; hz = longint'(bz[1]) - bz[0];
         tx = longint'(bx[tg]) - bx[0]; tz = longint'(bz[tg]) - bz[0];
         hm = hx*hx + hz*hz;
         tm = tx*tx + tz*tz;
         if (tm < {32'd0, arrive_sq}) begin
            if (dstate != wsc_pkg::CMD_STOP || last_tgt != tg) begin
               last_tgt = tg; route_step++; rep_cnt = 0;
               push(wsc_pkg::CMD_STOP, tg, 1'b1, 1'b0);
            end else repeat_or_resend(wsc_pkg::CMD_STOP, tg);
            return;
         end
         if (hm == 0 || tm == 0) return;
         dot = hx*tx + hz*tz;
         if (cos_above(dot, hm, tm, longint'(turn_lim))) begin
            if (dstate != wsc_pkg::CMD_TURN) begin
               rep_cnt = 0; push(wsc_pkg::CMD_TURN, tg, 1'b0, 1'b0);
            end else repeat_or_resend(wsc_pkg::CMD_TURN, tg);
         end else if (cos_above(-dot, hm, tm, -longint'(drive_lim))) begin
            if (dstate == wsc_pkg::CMD_TURN) begin
               rep_cnt = 0; push(wsc_pkg::CMD_STOP, tg, 1'b0, 1'b0);   // stop before driving off
            end else if (dstate != wsc_pkg::CMD_DRIVE) begin
               rep_cnt = 0; push(wsc_pkg::CMD_DRIVE, tg, 1'b0, 1'b0);
            end else repeat_or_resend(wsc_pkg::CMD_DRIVE, tg);
         end
      endfunction

      function void note_word(bit cmd, logic [2:0] bi, logic [15:0] x, logic [15:0] z,
                              bit fe, logic [2:0] dest);
         if (cmd) begin
            if (route[route_count-1] == dest) return;
            if (route_count < 16) begin
               route[route_count] = dest; route_count++;
            end
            return;
         end
         bx[bi] = x; bz[bi] = z;
         if (!fe) return;
         if (phase != skip) begin
            phase = phase + 4'd1;
            return;
         end
         phase = 4'd0;
         evaluate();
      endfunction

      function void check_word(logic [1:0] c, logic [2:0] tg, logic a, logic r);
         steer_word_type w;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word cmd=%0d target=%0d arrived=%0b resent=%0b",
                     $time, c, tg, a, r);
            errors++;
            return;
         end
         w = expected_words.pop_front();
         if (w.cmd != c) begin
            $display("%0t: drive_cmd expected %0d actual %0d", $time, w.cmd, c); errors++;
         end
         if (w.tgt != tg) begin
            $display("%0t: target expected %0d actual %0d", $time, w.tgt, tg); errors++;
         end
         if (w.arr != a) begin
            $display("%0t: arrived expected %0b actual %0b", $time, w.arr, a); errors++;
         end
         if (w.rs != r) begin
            $display("%0t: resent expected %0b actual %0b", $time, w.rs, r); errors++;
         end
      endfunction
   endclass

   logic               clock, reset;
   logic               req_valid, req_stall, req_command, req_frame_end;
   logic [2:0]         req_body_index, req_order_dest;
   logic signed [15:0] req_pos_x, req_pos_z;
   logic               rsp_valid, rsp_stall, rsp_arrived, rsp_resent;
   logic [1:0]         rsp_drive_cmd;
   logic [2:0]         rsp_target;
   logic               csr_write;
   logic [2:0]         csr_index;
   logic [31:0]        csr_data;

   steer_book_type book = new();
   int  cycle_count = 0;
   int  hold_request = 0, hold_seen = 0, hold_left = 0;
   int  window = 0, stall_pct = 0;
   int  burst_left = 0;
   int  fx[8], fz[8];

   waypoint_steering_controller_top uut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("waypoint_steering_controller_top_tb failed");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         book.check_word(rsp_drive_cmd, rsp_target, rsp_arrived, rsp_resent);

   // receiver: windows of random stall density, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_stall <= 0;
      else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else if (hold_seen != hold_request) begin
         hold_seen <= hold_request;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1;
      end else begin
         if (window == 0) begin
            window <= $urandom_range(20, 80);
            case ($urandom_range(0, 3))
               0: stall_pct <= 0;
               1: stall_pct <= 20;
               2: stall_pct <= 50;
               default: stall_pct <= 85;
            endcase
         end else window <= window - 1;
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   function automatic int spread(int m);
      return int'($urandom_range(0, 2*m)) - m;
   endfunction

   task automatic send_word(bit cmd, logic [2:0] bi, int x, int z, bit fe, logic [2:0] dest);
      req_valid      <= 1;
      req_command    <= cmd;
      req_body_index <= bi;
      req_pos_x      <= x[15:0];
      req_pos_z      <= z[15:0];
      req_frame_end  <= fe;
      req_order_dest <= dest;
      do @(posedge clock); while (req_stall);
      book.note_word(cmd, bi, x[15:0], z[15:0], fe, dest);
      if (burst_left <= 0) begin
         int gap;
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
      end else burst_left--;
   endtask

   task automatic send_order(bit dup);
      logic [2:0] d;
      d = dup ? book.tail_dest() : 3'($urandom_range(1, 7));
      send_word(1'b1, 3'($urandom_range(0, 7)), spread(32767), spread(32767),
                1'($urandom_range(0, 1)), d);
   endtask

   // one frame of samples; brief frames carry only robot, heading marker and target
   task automatic send_frame(frame_kind_type kind, bit brief, bit drop_end, output int n);
      int t, b0x, b0z, dx, dz;
      int order[$];
      t = book.cur_target();
      if (t == 0) t = 2;
      if (kind != FR_SAME && kind != FR_EXTREME)
         for (int i = 0; i < 8; i++) begin
            fx[i] = spread(32767); fz[i] = spread(32767);
         end
      b0x = spread(10000); b0z = spread(10000);
      dx = spread(9000); dz = spread(9000);
      case (kind)
         FR_NEAR: begin
            fx[0] = b0x; fz[0] = b0z;
            fx[t] = b0x + spread(300); fz[t] = b0z + spread(300);
         end
         FR_OPPOSE, FR_ALIGN: begin
            fx[0] = b0x; fz[0] = b0z;
            fx[t] = b0x + dx; fz[t] = b0z + dz;
            if (kind == FR_OPPOSE) begin
               fx[1] = b0x - dx/2 + spread(40); fz[1] = b0z - dz/2 + spread(40);
            end else begin
               fx[1] = b0x + dx/2 + spread(3000); fz[1] = b0z + dz/2 + spread(3000);
            end
         end
         FR_ZERO: begin
            fx[1] = fx[0]; fz[1] = fz[0];
         end
         FR_EXTREME: begin
            fx[0] = -32768; fz[0] = 32767;
            for (int i = 1; i < 8; i++) begin fx[i] = 32767; fz[i] = -32768; end
         end
         default: ;
      endcase
      if (brief) begin
         order.push_back(0); order.push_back(1);
         if (t > 1) order.push_back(t);
      end else for (int i = 0; i < 8; i++) order.push_back(i);
      n = order.size();
      foreach (order[i])
         send_word(1'b0, 3'(order[i]), fx[order[i]], fz[order[i]],
                   (i == n-1) && !drop_end, 3'($urandom_range(0, 7)));
   endtask

   task automatic write_regs(logic [31:0] arr, int turn, int drv, int rep, int skp);
      logic [31:0] v;
      for (int i = wsc_pkg::CSR_ARRIVE; i <= wsc_pkg::CSR_SKIP; i++) begin
         case (wsc_pkg::csr_index_type'(i))
            wsc_pkg::CSR_ARRIVE: v = arr;
            wsc_pkg::CSR_TURN:   v = turn;
            wsc_pkg::CSR_DRIVE:  v = drv;
            wsc_pkg::CSR_REPEAT: v = rep;
            default:             v = skp;
         endcase
         csr_write <= 1;
         csr_index <= wsc_pkg::csr_index_type'(i);
         csr_data  <= v;
         @(posedge clock);
         book.set_reg(wsc_pkg::csr_index_type'(i), v);
      end
      csr_write <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (book.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic random_phase(int items, bit with_hold);
      int done, n, r;
      done = 0;
      while (done < items) begin
         r = $urandom_range(0, 15);
         if (with_hold && done > items/3 && hold_request == 0) hold_request++;
         if (r == 0) begin
            send_order($urandom_range(0, 2) == 0);
            done++;
         end else if (r == 1) begin
            send_word(1'b0, 3'($urandom_range(0, 7)), spread(32767), spread(32767),
                      1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
            done++;
         end else begin
            send_frame(frame_kind_type'($urandom_range(FR_RANDOM, FR_SAME)),
                       $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0, n);
            done += n;
         end
      end
   endtask

   initial begin
      int n;
      reset = 1;
      req_valid = 0; req_command = 0; req_body_index = 0; req_pos_x = 0; req_pos_z = 0;
      req_frame_end = 0; req_order_dest = 1;
      csr_write = 0; csr_index = wsc_pkg::CSR_ARRIVE; csr_data = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: skip 0 and short repeat limit; frames are evaluated once the phase, reset to 1, wraps to 0
      write_regs(32'd160000, -31651, -32270, 2, 0);
      send_frame(FR_EXTREME, 1'b1, 1'b0, n);
      send_frame(FR_ZERO, 1'b1, 1'b0, n);
      send_frame(FR_ALIGN, 1'b1, 1'b0, n);
      send_frame(FR_OPPOSE, 1'b1, 1'b0, n);
      send_frame(FR_SAME, 1'b1, 1'b0, n);
      send_frame(FR_SAME, 1'b1, 1'b0, n);
      send_frame(FR_NEAR, 1'b1, 1'b0, n);
      send_order(1'b1);
      send_order(1'b0);
      random_phase(130, 1'b0);
      drain();

      write_regs(32'd0, 32767, -32768, 0, 1);
      random_phase(130, 1'b0);
      drain();

      write_regs(32'd1000000, 0, -20000, 5, 15);
      random_phase(130, 1'b0);
      drain();

      write_regs(32'd90000, -31651, -32270, 20, 4);
      random_phase(140, 1'b1);
      drain();

      write_regs(32'd250000, 20000, -30000, 1, 0);
      random_phase(130, 1'b0);
      drain();

      write_regs(32'hFFFF_FFFF, -32768, 32767, 255, 0);
      random_phase(100, 1'b0);
      drain();

      if (book.errors == 0 && book.pending() == 0)
         $display("waypoint_steering_controller_top_tb passed");
      else
         $display("waypoint_steering_controller_top_tb failed");
      $finish;
   end

endmodule

### filelist.f
rtl/wsc_pkg.sv
rtl/wsc_ctrl.sv
rtl/wsc_dp.sv
rtl/waypoint_steering_controller_top.sv
sim/waypoint_steering_controller_top_tb.sv
